>>> src/hotp_pkg.sv
// package for the hotp engine: sha-1 constants, state enum, round helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hotp_pkg;

    localparam int KEY_WORDS = 8;
    localparam int KW_BITS   = $clog2(KEY_WORDS);

    localparam logic [31:0] IPAD = 32'h36363636;
    localparam logic [31:0] OPAD = 32'h5C5C5C5C;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // which block the sha-1 core compresses
    typedef enum logic [1:0] {
        BLK_IKEY = 2'd0,
        BLK_MSG  = 2'd1,
        BLK_OKEY = 2'd2,
        BLK_HASH = 2'd3
    } blk_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_START = 3'd1,
        ST_HASH  = 3'd2,
        ST_TRUNC = 3'd3,
        ST_MOD   = 3'd4,
        ST_OUT   = 3'd5
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20)      k = 32'h5A827999;
            else if (r < 7'd40) k = 32'h6ED9EBA1;
            else if (r < 7'd60) k = 32'h8F1BBCDC;
            else                k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20)      f = (b & c) | (~b & d);
            else if (r < 7'd40) f = b ^ c ^ d;
            else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
            else                f = b ^ c ^ d;
            return f;
        end
    endfunction

endpackage

`default_nettype wire

>>> src/hotp_sha1_core.sv
// iterative sha-1 compression: one round per cycle over a 16-word schedule window
// depends on hotp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hotp_sha1_core
    import hotp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [159:0] h_in,
    input  wire logic [511:0] block,
    output logic              busy,
    output logic              done,
    output logic [159:0]      h_out
);

    logic [511:0] w_reg, w_next;
    logic [159:0] abcde_reg, abcde_next;
    logic [159:0] h_reg, h_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    logic [31:0] a, b, c, d, e, wt, wnew, t;

    always_comb
    begin
        a  = abcde_reg[159:128];
        b  = abcde_reg[127:96];
        c  = abcde_reg[95:64];
        d  = abcde_reg[63:32];
        e  = abcde_reg[31:0];
        wt = w_reg[511:480];
        wnew = w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416] ^ w_reg[511:480];
        wnew = {wnew[30:0], wnew[31]};
        t = {a[26:0], a[31:27]} + round_f(rnd_reg, b, c, d) + e + round_k(rnd_reg) + wt;
    end

    always_comb
    begin
        w_next     = w_reg;
        abcde_next = abcde_reg;
        h_next     = h_reg;
        rnd_next   = rnd_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            w_next     = block;
            abcde_next = h_in;
            h_next     = h_in;
            rnd_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            w_next     = {w_reg[479:0], wnew};
            abcde_next = {t, a, {b[1:0], b[31:2]}, c, d};
            rnd_next   = rnd_reg + 7'd1;
            if (rnd_reg == 7'd79)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                h_next = {h_reg[159:128] + t, h_reg[127:96] + a,
                          h_reg[95:64] + {b[1:0], b[31:2]},
                          h_reg[63:32] + c, h_reg[31:0] + d};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg  <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        abcde_reg <= abcde_next;
        h_reg     <= h_next;
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign h_out = h_reg;

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && rnd_reg == 7'd79 && !start) |=> (done_reg && !busy_reg))
        else $error("done missing after last round");
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rnd_reg < 7'd80)
        else $error("round counter overrun");

endmodule

`default_nettype wire

>>> src/hotp_hmac_sha1_engine.sv
// hotp engine top level: key store, hmac sequencer, truncation and decimal modulo
// depends on hotp_pkg and hotp_sha1_core
//
// usage: one input channel (valid/ready) carries transactions; action 0 writes
// key_word into key store word word_index and returns nothing; action 1 computes
// hmac-sha1 over the big-endian counter with the stored 64-byte zero-padded key,
// then returns the dynamically truncated 31-bit value and that value modulo
// 10^digit_count (digit counts above nine act as nine) on the output channel.
// a compute runs four sha-1 compressions of 80 rounds on one shared round unit
// (one round per cycle), a truncation step and a restoring subtract modulo with
// 31 compare/subtract steps; the next transaction can be accepted in the cycle
// after the result is taken. ready is low while a compute runs and while its
// result waits; a stalled receiver holds the result and the engine.
// reset clears the key store to zero and returns the engine to idle.
`timescale 1ns / 1ps
`default_nettype none

module hotp_hmac_sha1_engine
    import hotp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [2:0]  word_index,
    input  wire logic [63:0] key_word,
    input  wire logic [31:0] counter,
    input  wire logic [3:0]  digit_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [29:0]      otp_code,
    output logic [30:0]      truncated_value
);

    state_t state_reg, state_next;
    logic [63:0] key_reg [KEY_WORDS];
    logic [31:0] ctr_reg;
    logic [3:0]  dig_reg;
    blk_sel_t    blk_reg, blk_next;
    logic [159:0] inner_reg, inner_next;
    logic [159:0] chain_reg, chain_next;
    logic [30:0] trunc_reg, trunc_next;
    logic [30:0] rem_reg, rem_next;
    logic [59:0] div_reg, div_next;   // modulus shifted left
    logic [5:0]  step_reg, step_next;

    logic        core_start;
    logic        core_busy;
    logic        core_done;
    logic [159:0] h_in, h_out;
    logic [511:0] block, key_blk;
    logic [31:0] pad;
    logic        accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        pad = (blk_reg == BLK_IKEY) ? IPAD : OPAD;
        for (int i = 0; i < 8; i++)
            key_blk[511 - 64*i -: 64] = ((i < KEY_WORDS) ? key_reg[i[KW_BITS-1:0]] : 64'd0)
                                        ^ {pad, pad};
        case (blk_reg)
            BLK_IKEY: block = key_blk;
            BLK_OKEY: block = key_blk;
            BLK_MSG:  block = {32'd0, ctr_reg, 32'h80000000, 384'd0, 32'd576};
            BLK_HASH: block = {inner_reg, 32'h80000000, 288'd0, 32'd672};
            default:  block = key_blk;
        endcase
        h_in = (blk_reg == BLK_IKEY || blk_reg == BLK_OKEY) ? SHA1_IV : chain_reg;
    end

    assign core_start = (state_reg == ST_START);

    hotp_sha1_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .h_in  (h_in),
        .block (block),
        .busy  (core_busy),
        .done  (core_done),
        .h_out (h_out)
    );

    // pow10 table, saturating at nine digits
    function automatic logic [29:0] pow10(input logic [3:0] n);
        logic [29:0] p;
        begin
            case (n)
                4'd0: p = 30'd1;
                4'd1: p = 30'd10;
                4'd2: p = 30'd100;
                4'd3: p = 30'd1000;
                4'd4: p = 30'd10000;
                4'd5: p = 30'd100000;
                4'd6: p = 30'd1000000;
                4'd7: p = 30'd10000000;
                4'd8: p = 30'd100000000;
                default: p = 30'd1000000000;
            endcase
            return p;
        end
    endfunction

    logic [3:0]  off;
    logic [159:0] dsh;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept && action == ACT_COMPUTE) state_next = ST_START;
            ST_START: state_next = ST_HASH;
            ST_HASH:
                if (core_done)
                    state_next = (blk_reg == BLK_HASH) ? ST_TRUNC : ST_START;
            ST_TRUNC: state_next = ST_MOD;
            ST_MOD:   if (step_reg == 6'd0) state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        blk_next   = blk_reg;
        inner_next = inner_reg;
        chain_next = chain_reg;
        trunc_next = trunc_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        off = h_out[3:0];
        dsh = h_out << {off, 3'b000};
        case (state_reg)
            ST_IDLE:
                if (accept && action == ACT_COMPUTE)
                    blk_next = BLK_IKEY;
            ST_HASH:
                if (core_done)
                begin
                    chain_next = h_out;
                    if (blk_reg == BLK_MSG)
                        inner_next = h_out;
                    case (blk_reg)
                        BLK_IKEY: blk_next = BLK_MSG;
                        BLK_MSG:  blk_next = BLK_OKEY;
                        BLK_OKEY: blk_next = BLK_HASH;
                        default:  blk_next = BLK_HASH;
                    endcase
                end
            ST_TRUNC:
            begin
                trunc_next = dsh[158:128];
                rem_next   = dsh[158:128];
                div_next   = {pow10(dig_reg), 30'd0};
                step_next  = 6'd30;
            end
            ST_MOD:
            begin
                // restoring reduction: subtract m * 2^step where it fits
                if ({29'd0, rem_reg} >= div_reg)
                    rem_next = rem_reg - div_reg[30:0];
                div_next = div_reg >> 1;
                if (step_reg != 6'd0)
                    step_next = step_reg - 6'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < KEY_WORDS; i++)
                key_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && action == ACT_LOAD && 32'(word_index) < KEY_WORDS)
                key_reg[word_index[KW_BITS-1:0]] <= key_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctr_reg <= counter;
            dig_reg <= digit_count;
        end
        blk_reg   <= blk_next;
        inner_reg <= inner_next;
        chain_reg <= chain_next;
        trunc_reg <= trunc_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        step_reg  <= step_next;
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = (state_reg == ST_OUT);
    assign otp_code        = rem_reg[29:0];
    assign truncated_value = trunc_reg;

    a_result_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, otp_code} < {1'b0, pow10(dig_reg)}))
        else $error("otp code not reduced");
    a_code_le_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, otp_code} <= truncated_value))
        else $error("otp code above truncated value");
    a_core_idle_outside_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_OUT) |-> !core_busy)
        else $error("core busy outside hashing");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(otp_code)))
        else $error("result dropped under stall");

endmodule

`default_nettype wire

>>> tb/hotp_hmac_sha1_engine_test.sv
// testbench for hotp_hmac_sha1_engine: directed table then random load/compute traffic
// depends on hotp_pkg and the engine rtl; own hmac-sha1 hotp predictor inside
`timescale 1ns / 1ps

module hotp_hmac_sha1_engine_test;
    import hotp_pkg::*;

    typedef struct {
        logic        act;
        logic [2:0]  idx;
        logic [63:0] kw;
        logic [31:0] ctr;
        logic [3:0]  dig;
        logic        chk;
        logic [29:0] x_code;
        logic [30:0] x_trunc;
    } stim_row_t;

    typedef struct {
        logic [29:0] code;
        logic [30:0] trunc;
        logic        fixed;
        logic [29:0] f_code;
        logic [30:0] f_trunc;
    } otp_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [2:0]  word_index = '0;
    logic [63:0] key_word = '0;
    logic [31:0] counter = '0;
    logic [3:0]  digit_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [29:0] otp_code;
    logic [30:0] truncated_value;

    logic [63:0] key_model [KEY_WORDS];
    otp_exp_t    otp_queue [$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off = 0;

    localparam int CYCLE_LIMIT = 3_000_000;

    hotp_hmac_sha1_engine u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .word_index(word_index), .key_word(key_word),
        .counter(counter), .digit_count(digit_count), .out_valid(out_valid),
        .out_ready(out_ready), .otp_code(otp_code), .truncated_value(truncated_value)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] compress(input logic [159:0] h, input logic [511:0] blk);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        begin
            for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
            for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            {a, b, c, d, e} = h;
            for (int i = 0; i < 80; i++) begin
                if (i < 20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
                else if (i < 40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
                else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
                else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
                t = rol(a, 5) + f + e + k + w[i];
                e = d; d = c; c = rol(b, 30); b = a; a = t;
            end
            return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
        end
    endfunction

    function automatic logic [511:0] padded_key(input logic [31:0] pad);
        logic [511:0] blk;
        begin
            for (int i = 0; i < 8; i++)
                blk[511 - 64*i -: 64] = key_model[i] ^ {pad, pad};
            return blk;
        end
    endfunction

    function automatic void hotp_predict(input logic [31:0] ctr, input logic [3:0] dig,
                                         output logic [29:0] code, output logic [30:0] trunc);
        logic [159:0] inner, outer;
        logic [511:0] blk;
        logic [3:0]   off;
        logic [31:0]  v, m;
        int           nd;
        begin
            inner = compress(SHA1_IV, padded_key(IPAD));
            blk = '0;
            blk[479:448] = ctr;
            blk[447:416] = 32'h80000000;
            blk[31:0] = 32'd576;
            inner = compress(inner, blk);
            outer = compress(SHA1_IV, padded_key(OPAD));
            blk = '0;
            blk[511:352] = inner;
            blk[351:320] = 32'h80000000;
            blk[31:0] = 32'd672;
            outer = compress(outer, blk);
            off = outer[3:0];
            v = outer[159 - 8*off -: 32];
            trunc = v[30:0];
            nd = (dig > 9) ? 9 : dig;
            m = 1;
            for (int i = 0; i < nd; i++) m = m * 10;
            code = 30'({1'b0, trunc} % m);
        end
    endfunction

    task automatic send_item(input stim_row_t r);
        otp_exp_t x;
        begin
            while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            action <= r.act;
            word_index <= r.idx;
            key_word <= r.kw;
            counter <= r.ctr;
            digit_count <= r.dig;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            if (r.act == ACT_LOAD) begin
                key_model[r.idx] = r.kw;
            end
            else begin
                hotp_predict(r.ctr, r.dig, x.code, x.trunc);
                x.fixed = r.chk;
                x.f_code = r.x_code;
                x.f_trunc = r.x_trunc;
                otp_queue.push_back(x);
            end
        end
    endtask

    task automatic drain_all();
        begin
            in_valid <= 1'b0;
            while (otp_queue.size() != 0) @(posedge clk);
            repeat (400) @(posedge clk);
        end
    endtask

    function automatic stim_row_t load_row(input logic [2:0] i, input logic [63:0] w);
        stim_row_t r;
        r = '{ACT_LOAD, i, w, $urandom, 4'($urandom_range(15, 0)), 1'b0, '0, '0};
        return r;
    endfunction

    function automatic stim_row_t calc_row(input logic [31:0] c, input logic [3:0] d);
        stim_row_t r;
        r = '{ACT_COMPUTE, 3'($urandom), {$urandom, $urandom}, c, d, 1'b0, '0, '0};
        return r;
    endfunction

    function automatic stim_row_t rand_row();
        int sel;
        begin
            sel = $urandom_range(99, 0);
            if (sel < 40)
                return load_row(3'($urandom), {$urandom, $urandom});
            else if (sel < 45)
                return load_row(3'($urandom), $urandom_range(1, 0) ? 64'h0 : '1);
            else if (sel < 90)
                return calc_row($urandom, 4'($urandom_range(9, 1)));
            else
                return calc_row($urandom_range(1, 0) ? $urandom_range(3, 0) : $urandom,
                                4'($urandom));
        end
    endfunction

    // result checker
    always @(posedge clk) begin
        otp_exp_t x;
        if (rst_n && out_valid && out_ready) begin
            if (otp_queue.size() == 0) begin
                $error("unexpected result otp_code=%0d truncated_value=%0d",
                       otp_code, truncated_value);
                errors++;
            end
            else begin
                x = otp_queue.pop_front();
                if (x.fixed) begin
                    x.code = x.f_code;
                    x.trunc = x.f_trunc;
                end
                if (otp_code !== x.code) begin
                    $error("otp_code expected %0d actual %0d", x.code, otp_code);
                    errors++;
                end
                if (truncated_value !== x.trunc) begin
                    $error("truncated_value expected %0d actual %0d", x.trunc, truncated_value);
                    errors++;
                end
            end
        end
    end

    // receiver side ready
    always @(posedge clk) begin
        if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("hotp_hmac_sha1_engine_test: errors");
            $finish;
        end
    end

    stim_row_t dir_table [$];

    initial begin
        for (int i = 0; i < KEY_WORDS; i++) key_model[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero key after reset, digit count zero gives code zero
        dir_table.push_back(calc_row(32'h0, 4'd0));
        dir_table.push_back(calc_row(32'hFFFFFFFF, 4'd15));
        // rfc 4226 test key "12345678901234567890"
        dir_table.push_back(load_row(3'd0, 64'h3132333435363738));
        dir_table.push_back(load_row(3'd1, 64'h3930313233343536));
        dir_table.push_back(load_row(3'd2, 64'h3738393000000000));
        dir_table.push_back('{ACT_COMPUTE, 3'd0, 64'h0, 32'd0, 4'd6, 1'b1,
                              30'd755224, 31'h4c93cf18});
        dir_table.push_back('{ACT_COMPUTE, 3'd7, '1, 32'd1, 4'd6, 1'b1,
                              30'd287082, 31'h41397eea});
        dir_table.push_back(calc_row(32'd9, 4'd9));
        dir_table.push_back(calc_row(32'd9, 4'd10));
        dir_table.push_back(calc_row(32'd9, 4'd1));
        // full 64-byte key with zero bytes inside: all-ones words alternating with 00FF00FF00000000
        for (int i = 0; i < KEY_WORDS; i++)
            dir_table.push_back(load_row(3'(i), (i % 2) ? 64'h00FF00FF00000000 : '1));
        dir_table.push_back(calc_row(32'h80000000, 4'd8));
        dir_table.push_back(calc_row(32'h7FFFFFFF, 4'd0));
        foreach (dir_table[i]) send_item(dir_table[i]);
        drain_all();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 16) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 71 : 16) : 0;
            if (ph == 2) hold_off <= 3000;
            for (int n = 0; n < 320; n++) begin
                send_item(rand_row());
                if (n == 160) drain_all();
            end
            drain_all();
        end
        drain_all();
        if (errors == 0)
            $display("hotp_hmac_sha1_engine_test: clean");
        else
            $display("hotp_hmac_sha1_engine_test: errors");
        $finish;
    end

endmodule
